// ===== hw/rtl/shad_pkg.sv =====
// Shared types, codes and constants for the six-axis HID report decoder.
// Used by every module but shad_fifo; depends on nothing else.

package shad_pkg;

    localparam int WORDS               = 6;
    localparam int WORD_W              = 16;
    localparam int CFG_W               = 6;
    localparam int MASK_W              = 32;
    localparam int POS_W               = $clog2(MASK_W);
    localparam int DEF_KEY_SLOTS       = 6;
    localparam int DEF_MAX_BUTTON_BITS = 32;
    localparam int JOB_DEPTH           = 2;
    localparam int RES_DEPTH           = 2;

    localparam logic [7:0] ID_MOTION = 8'h01;
    localparam logic [7:0] ID_ROTATE = 8'h02;
    localparam logic [7:0] ID_BITS   = 8'h03;
    localparam logic [7:0] ID_DUAL   = 8'h16;
    localparam logic [7:0] ID_KEYS   = 8'h1c;
    localparam logic [7:0] ID_HELD   = 8'h1d;

    localparam logic [CFG_W-1:0]  BITS_IN_USE_RESET = 6'd16;
    localparam logic [WORD_W-1:0] KEY_CODE_MIN      = 16'd32;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        KIND_TRANSLATE = 2'd0,
        KIND_ROTATE    = 2'd1,
        KIND_BUTTON    = 2'd2
    } event_kind_t;

    typedef enum logic [2:0] {
        JOB_MOTION,
        JOB_ROTATE,
        JOB_BITS,
        JOB_KEYS,
        JOB_HELD
    } job_kind_t;

    // One classified report: which positions give events, and the words they need.
    typedef struct packed {
        job_kind_t              kind;
        logic [MASK_W-1:0]      mask;
        word_t [WORDS-1:0]      w;
        word_t [WORDS-1:0]      p;
    } job_t;

    typedef struct packed {
        event_kind_t        kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        word_t              button;
        logic               pressed;
        logic               last;
    } res_t;

endpackage

// ===== hw/rtl/six_axis_hid_report_decoder.sv =====
// Top level of the six-axis HID report decoder: front end, job queue,
// back end sequencer and result queue. Uses shad_pkg and all shad_ modules.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   reports   push / full          report_id, long_report, word_0 .. word_5
//   events    pop / empty          event_kind, axis_x/y/z, button, pressed, last
//   config    cfg_valid/cfg_ready  cfg_data (bits_in_use)
//
// A report is classified in the cycle it is taken; a known one is queued as
// one job. The back end loads one job, then walks its event positions up to
// its last event: up to 32 positions for a bitwise report, up to 2*KEY_SLOTS
// for key codes, 1 to 2 for axis reports, up to 2 for held-key reports, and
// none for a report that gives no events.
// Reset clears all button state and sets bits_in_use to 16; no clearing pass.
// A full result queue stalls the back end; a full job queue raises full.

module six_axis_hid_report_decoder #(
    parameter int KEY_SLOTS       = shad_pkg::DEF_KEY_SLOTS,
    parameter int MAX_BUTTON_BITS = shad_pkg::DEF_MAX_BUTTON_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 report_id,
    input  logic                       long_report,
    input  logic [15:0]                word_0,
    input  logic [15:0]                word_1,
    input  logic [15:0]                word_2,
    input  logic [15:0]                word_3,
    input  logic [15:0]                word_4,
    input  logic [15:0]                word_5,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 event_kind,
    output logic signed [15:0]         axis_x,
    output logic signed [15:0]         axis_y,
    output logic signed [15:0]         axis_z,
    output logic [15:0]                button,
    output logic                       pressed,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [shad_pkg::CFG_W-1:0] cfg_data
);

    import shad_pkg::*;

    word_t [WORDS-1:0] words;
    job_t              job_in, job_head;
    logic              job_push, job_full, job_pop, job_empty;
    res_t              res_in, res_head;
    logic              res_push, res_full;

    assign words = {word_5, word_4, word_3, word_2, word_1, word_0};

    shad_front #(
        .KEY_SLOTS       (KEY_SLOTS),
        .MAX_BUTTON_BITS (MAX_BUTTON_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .report_id   (report_id),
        .long_report (long_report),
        .words       (words),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .job_push    (job_push),
        .job         (job_in),
        .job_full    (job_full)
    );

    shad_fifo #(
        .T     (job_t),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .empty   (job_empty)
    );

    shad_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_head  (job_head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    shad_fifo #(
        .T     (res_t),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign event_kind = res_head.kind;
    assign axis_x     = res_head.x;
    assign axis_y     = res_head.y;
    assign axis_z     = res_head.z;
    assign button     = res_head.button;
    assign pressed    = res_head.pressed;
    assign last       = res_head.last;

endmodule

// ===== hw/rtl/shad_fifo.sv =====
// Small register queue of any payload type.
// Depends on nothing; used for the job queue and the result queue.

module shad_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/shad_front.sv =====
// Front end: accepts reports, classifies them, keeps the button state and
// the bits_in_use register, and builds one job per known report. Uses shad_pkg.

module shad_front #(
    parameter int KEY_SLOTS       = shad_pkg::DEF_KEY_SLOTS,
    parameter int MAX_BUTTON_BITS = shad_pkg::DEF_MAX_BUTTON_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        report_id,
    input  logic                              long_report,
    input  shad_pkg::word_t [shad_pkg::WORDS-1:0] words,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [shad_pkg::CFG_W-1:0]        cfg_data,
    output logic                              job_push,
    output shad_pkg::job_t                    job,
    input  logic                              job_full
);

    import shad_pkg::*;

    logic [CFG_W-1:0]  bits_in_use_reg, bits_in_use_next;
    logic [MASK_W-1:0] prev_button_reg, prev_button_next;
    logic [MASK_W-1:0] prev_dual_reg, prev_dual_next;
    word_t             prev_key_reg [KEY_SLOTS];
    word_t             prev_key_next [KEY_SLOTS];
    word_t             prev_held_reg, prev_held_next;

    logic              accept;
    logic              known;
    logic [CFG_W-1:0]  count;
    logic [MASK_W-1:0] now_bits;
    logic [MASK_W-1:0] use_mask;
    logic [MASK_W-1:0] full_mask;
    word_t [WORDS-1:0] now_keys;
    word_t [WORDS-1:0] old_keys;
    logic              found;

    assign full      = job_full;
    assign accept    = push && !job_full;
    assign cfg_ready = 1'b1;
    assign job_push  = accept && known;
    assign now_bits  = {words[1], words[0]};

    always_comb
    begin
        count = (bits_in_use_reg > CFG_W'(MAX_BUTTON_BITS)) ?
                CFG_W'(MAX_BUTTON_BITS) : bits_in_use_reg;
        for (int i = 0; i < MASK_W; i++)
        begin
            use_mask[i]  = (CFG_W'(i) < count);
            full_mask[i] = (i < MAX_BUTTON_BITS);
        end
        for (int i = 0; i < WORDS; i++)
        begin
            now_keys[i] = '0;
            old_keys[i] = '0;
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            now_keys[i] = (words[i] <= KEY_CODE_MIN) ? '0 : words[i];
            old_keys[i] = prev_key_reg[i];
        end
    end

    // Classify and build the job.
    always_comb
    begin
        known    = 1'b1;
        job.kind = JOB_MOTION;
        job.mask = '0;
        job.w    = words;
        job.p    = '0;
        found    = 1'b0;
        unique case (report_id)
            ID_MOTION:
            begin
                job.kind    = JOB_MOTION;
                job.mask[0] = 1'b1;
                job.mask[1] = long_report;
            end
            ID_ROTATE:
            begin
                job.kind    = JOB_ROTATE;
                job.mask[0] = 1'b1;
            end
            ID_BITS:
            begin
                job.kind = JOB_BITS;
                job.mask = (prev_button_reg ^ now_bits) & use_mask;
            end
            ID_DUAL:
            begin
                job.kind = JOB_BITS;
                job.mask = (prev_dual_reg ^ now_bits) & full_mask;
            end
            ID_KEYS:
            begin
                job.kind = JOB_KEYS;
                job.w    = now_keys;
                job.p    = old_keys;
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    // down: new code not among the stored codes
                    found = 1'b0;
                    for (int j = 0; j < KEY_SLOTS; j++)
                    begin
                        found = found || (old_keys[j] == now_keys[i]);
                    end
                    job.mask[i] = (now_keys[i] != '0) && !found;
                    // up: stored code gone from the new codes
                    found = 1'b0;
                    for (int j = 0; j < KEY_SLOTS; j++)
                    begin
                        found = found || (now_keys[j] == old_keys[i]);
                    end
                    job.mask[KEY_SLOTS + i] = (old_keys[i] != '0) && !found;
                end
            end
            ID_HELD:
            begin
                job.kind    = JOB_HELD;
                job.p[0]    = prev_held_reg;
                job.mask[0] = (prev_held_reg != '0) && (words[0] != prev_held_reg);
                job.mask[1] = (words[0] != '0);
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // State updates.
    always_comb
    begin
        bits_in_use_next = bits_in_use_reg;
        prev_button_next = prev_button_reg;
        prev_dual_next   = prev_dual_reg;
        prev_held_next   = prev_held_reg;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            prev_key_next[i] = prev_key_reg[i];
        end
        if (cfg_valid)
        begin
            bits_in_use_next = cfg_data;
        end
        if (accept)
        begin
            unique case (report_id)
                ID_BITS:
                begin
                    prev_button_next = now_bits;
                end
                ID_DUAL:
                begin
                    prev_dual_next = now_bits;
                end
                ID_KEYS:
                begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        prev_key_next[i] = now_keys[i];
                    end
                end
                ID_HELD:
                begin
                    prev_held_next = words[0];
                end
                default:
                begin
                    prev_held_next = prev_held_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= BITS_IN_USE_RESET;
            prev_button_reg <= '0;
            prev_dual_reg   <= '0;
            prev_held_reg   <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_key_reg[i] <= '0;
            end
        end
        else
        begin
            bits_in_use_reg <= bits_in_use_next;
            prev_button_reg <= prev_button_next;
            prev_dual_reg   <= prev_dual_next;
            prev_held_reg   <= prev_held_next;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_key_reg[i] <= prev_key_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/shad_back.sv =====
// Back end: takes one job at a time and walks its event positions, one a cycle unless
// a full result queue stalls it, pushing an event for each set mask bit. Uses shad_pkg.

module shad_back #(
    parameter int KEY_SLOTS = shad_pkg::DEF_KEY_SLOTS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  shad_pkg::job_t job_head,
    input  logic           job_empty,
    output logic           job_pop,
    output logic           res_push,
    output shad_pkg::res_t res,
    input  logic           res_full
);

    import shad_pkg::*;

    job_t              job_reg, job_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              busy;
    logic              stall;
    logic [MASK_W-1:0] now_bits;

    assign busy     = (mask_reg != '0);
    assign job_pop  = !busy && !job_empty;
    assign stall    = mask_reg[0] && res_full;
    assign res_push = mask_reg[0] && !res_full;
    assign now_bits = {job_reg.w[1], job_reg.w[0]};

    always_comb
    begin
        job_next  = job_reg;
        mask_next = mask_reg;
        pos_next  = pos_reg;
        if (job_pop)
        begin
            job_next  = job_head;
            mask_next = job_head.mask;
            pos_next  = '0;
        end
        else if (busy && !stall)
        begin
            mask_next = mask_reg >> 1;
            pos_next  = pos_reg + 1'b1;
        end
    end

    // Event at the current position.
    always_comb
    begin
        res.kind    = KIND_BUTTON;
        res.x       = '0;
        res.y       = '0;
        res.z       = '0;
        res.button  = '0;
        res.pressed = 1'b0;
        res.last    = (mask_reg[MASK_W-1:1] == '0);
        unique case (job_reg.kind)
            JOB_MOTION, JOB_ROTATE:
            begin
                if (job_reg.kind == JOB_MOTION && pos_reg == '0)
                begin
                    res.kind = KIND_TRANSLATE;
                    res.x    = job_reg.w[0];
                    res.y    = 16'd0 - job_reg.w[2];
                    res.z    = job_reg.w[1];
                end
                else if (job_reg.kind == JOB_MOTION)
                begin
                    res.kind = KIND_ROTATE;
                    res.x    = job_reg.w[3];
                    res.y    = 16'd0 - job_reg.w[5];
                    res.z    = job_reg.w[4];
                end
                else
                begin
                    res.kind = KIND_ROTATE;
                    res.x    = job_reg.w[0];
                    res.y    = 16'd0 - job_reg.w[2];
                    res.z    = job_reg.w[1];
                end
            end
            JOB_BITS:
            begin
                res.button  = WORD_W'(pos_reg) + 1'b1;
                res.pressed = now_bits[pos_reg];
            end
            JOB_KEYS:
            begin
                // down positions first, then up positions
                for (int k = 0; k < KEY_SLOTS; k++)
                begin
                    if (pos_reg == POS_W'(k))
                    begin
                        res.button  = job_reg.w[k];
                        res.pressed = 1'b1;
                    end
                    if (pos_reg == POS_W'(KEY_SLOTS + k))
                    begin
                        res.button  = job_reg.p[k];
                        res.pressed = 1'b0;
                    end
                end
            end
            JOB_HELD:
            begin
                if (pos_reg == '0)
                begin
                    res.button  = job_reg.p[0];
                    res.pressed = 1'b0;
                end
                else
                begin
                    res.button  = job_reg.w[0];
                    res.pressed = 1'b1;
                end
            end
            default:
            begin
                res.kind = KIND_BUTTON;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// ===== verif/tb_six_axis_hid_report_decoder.sv =====
// Self-checking testbench for the six-axis HID report decoder: a scoreboard
// class predicts the event stream of each report; tasks drive push and config.
// A sink process drives pop. Depends on shad_pkg and six_axis_hid_report_decoder.
`timescale 1ns / 1ps

module tb_six_axis_hid_report_decoder;

    import shad_pkg::*;

    localparam int KEY_SLOTS       = DEF_KEY_SLOTS;
    localparam int MAX_BUTTON_BITS = DEF_MAX_BUTTON_BITS;
    localparam int PHASE_ITEMS     = 65;
    localparam int DRAIN_CYCLES    = 100;
    localparam int IDLE_LIMIT      = 2000;

    typedef struct packed {
        logic [7:0]          id;
        logic                long_rep;
        word_t [WORDS-1:0]   w;
    } hid_report_t;

    class hid_event_scoreboard;
        res_t                         expected_events[$];
        logic [CFG_W-1:0]             bits_in_use;
        logic [MASK_W-1:0]            prev_button_bits;
        logic [MASK_W-1:0]            prev_dual_bits;
        word_t [KEY_SLOTS-1:0]        prev_key_codes;
        word_t                        prev_held_key;
        int                           fails;

        function new();
            bits_in_use      = BITS_IN_USE_RESET;
            prev_button_bits = '0;
            prev_dual_bits   = '0;
            prev_key_codes   = '0;
            prev_held_key    = '0;
            fails            = 0;
        endfunction

        function void add_event(event_kind_t kind, word_t x, word_t y, word_t z,
                                word_t code, logic down);
            res_t e;
            e.kind    = kind;
            e.x       = x;
            e.y       = y;
            e.z       = z;
            e.button  = code;
            e.pressed = down;
            e.last    = 1'b0;
            expected_events.push_back(e);
        endfunction

        // Reorder to (a, -c, b); the negation wraps in 16 bits.
        function void add_axes(event_kind_t kind, word_t a, word_t b, word_t c);
            add_event(kind, a, word_t'(16'h0000 - c), b, '0, 1'b0);
        endfunction

        function void scan_bits(logic [MASK_W-1:0] old_mask, logic [MASK_W-1:0] cur_mask,
                                int count);
            for (int i = 0; i < count; i++) begin
                if (old_mask[i] && !cur_mask[i])
                    add_event(KIND_BUTTON, '0, '0, '0, word_t'(i + 1), 1'b0);
                else if (!old_mask[i] && cur_mask[i])
                    add_event(KIND_BUTTON, '0, '0, '0, word_t'(i + 1), 1'b1);
            end
        endfunction

        function bit holds_code(word_t [KEY_SLOTS-1:0] list, word_t code);
            for (int j = 0; j < KEY_SLOTS; j++)
                if (list[j] == code)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_report(hid_report_t r);
            int                    start;
            int                    count;
            logic [MASK_W-1:0]     cur_mask;
            word_t [KEY_SLOTS-1:0] cur_keys;
            start    = expected_events.size();
            cur_mask = {r.w[1], r.w[0]};
            case (r.id)
                ID_MOTION: begin
                    add_axes(KIND_TRANSLATE, r.w[0], r.w[1], r.w[2]);
                    if (r.long_rep)
                        add_axes(KIND_ROTATE, r.w[3], r.w[4], r.w[5]);
                end
                ID_ROTATE: add_axes(KIND_ROTATE, r.w[0], r.w[1], r.w[2]);
                ID_BITS: begin
                    count = (int'(bits_in_use) > MAX_BUTTON_BITS) ? MAX_BUTTON_BITS
                                                                 : int'(bits_in_use);
                    scan_bits(prev_button_bits, cur_mask, count);
                    prev_button_bits = cur_mask;
                end
                ID_DUAL: begin
                    scan_bits(prev_dual_bits, cur_mask, MAX_BUTTON_BITS);
                    prev_dual_bits = cur_mask;
                end
                ID_KEYS: begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                        cur_keys[i] = (r.w[i] <= KEY_CODE_MIN) ? '0 : r.w[i];
                    // presses first in slot order, then releases
                    for (int i = 0; i < KEY_SLOTS; i++)
                        if (cur_keys[i] != '0 && !holds_code(prev_key_codes, cur_keys[i]))
                            add_event(KIND_BUTTON, '0, '0, '0, cur_keys[i], 1'b1);
                    for (int i = 0; i < KEY_SLOTS; i++)
                        if (prev_key_codes[i] != '0 && !holds_code(cur_keys, prev_key_codes[i]))
                            add_event(KIND_BUTTON, '0, '0, '0, prev_key_codes[i], 1'b0);
                    prev_key_codes = cur_keys;
                end
                ID_HELD: begin
                    if (prev_held_key != '0 && r.w[0] != prev_held_key)
                        add_event(KIND_BUTTON, '0, '0, '0, prev_held_key, 1'b0);
                    if (r.w[0] != '0)
                        add_event(KIND_BUTTON, '0, '0, '0, r.w[0], 1'b1);
                    prev_held_key = r.w[0];
                end
                default: ;
            endcase
            if (expected_events.size() > start)
                expected_events[expected_events.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_event(res_t got);
            res_t want;
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d button %0d", got.kind, got.button);
                fails++;
                return;
            end
            want = expected_events.pop_front();
            if ($isunknown(got)) begin
                $error("event carries unknown bits: %h", got);
                fails++;
            end
            compare_field("event_kind", want.kind, got.kind);
            compare_field("axis_x", want.x, got.x);
            compare_field("axis_y", want.y, got.y);
            compare_field("axis_z", want.z, got.z);
            compare_field("button", want.button, got.button);
            compare_field("pressed", want.pressed, got.pressed);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              push        = 1'b0;
    logic              full;
    logic [7:0]        report_id   = '0;
    logic              long_report = 1'b0;
    logic [15:0]       word_0      = '0;
    logic [15:0]       word_1      = '0;
    logic [15:0]       word_2      = '0;
    logic [15:0]       word_3      = '0;
    logic [15:0]       word_4      = '0;
    logic [15:0]       word_5      = '0;
    logic              empty;
    logic              pop         = 1'b0;
    logic [1:0]        event_kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]       button;
    logic              pressed;
    logic              last;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data    = '0;

    hid_event_scoreboard sb = new();

    six_axis_hid_report_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .report_id   (report_id),
        .long_report (long_report),
        .word_0      (word_0),
        .word_1      (word_1),
        .word_2      (word_2),
        .word_3      (word_3),
        .word_4      (word_4),
        .word_5      (word_5),
        .empty       (empty),
        .pop         (pop),
        .event_kind  (event_kind),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z),
        .button      (button),
        .pressed     (pressed),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic hid_report_t make_report(logic [7:0] id, logic long_rep,
                                                word_t w0, word_t w1, word_t w2,
                                                word_t w3, word_t w4, word_t w5);
        hid_report_t r;
        r.id       = id;
        r.long_rep = long_rep;
        r.w        = {w5, w4, w3, w2, w1, w0};
        return r;
    endfunction

    function automatic word_t random_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0001;
            default: return word_t'($urandom);
        endcase
    endfunction

    // Favor codes around the 32 cutoff so that slots match across reports.
    function automatic word_t random_key_code();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return word_t'($urandom_range(1, 32));
            2, 3, 4: return word_t'($urandom_range(32, 37));
            5:       return 16'hFFFF;
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic hid_report_t random_report();
        hid_report_t r;
        r.long_rep = 1'($urandom_range(0, 1));
        for (int i = 0; i < WORDS; i++)
            r.w[i] = random_word();
        case ($urandom_range(0, 19))
            0, 1, 2:     r.id = ID_MOTION;
            3, 4:        r.id = ID_ROTATE;
            5, 6, 7:     r.id = ID_BITS;
            8, 9, 10:    r.id = ID_DUAL;
            11, 12, 13,
            14:          r.id = ID_KEYS;
            15, 16, 17:  r.id = ID_HELD;
            default:     r.id = 8'($urandom_range(0, 255));
        endcase
        if (r.id == ID_KEYS || r.id == ID_HELD)
            for (int i = 0; i < KEY_SLOTS; i++)
                r.w[i] = random_key_code();
        return r;
    endfunction

    task automatic send_report(hid_report_t r);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        report_id   <= r.id;
        long_report <= r.long_rep;
        word_0      <= r.w[0];
        word_1      <= r.w[1];
        word_2      <= r.w[2];
        word_3      <= r.w[3];
        word_4      <= r.w[4];
        word_5      <= r.w[5];
        do @(posedge clk); while (full);
        sb.note_report(r);
    endtask

    // Drop push, wait out all expected events, then let the back end settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bits_in_use(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.bits_in_use = value;
    endtask

    initial begin
        int settings[7];
        settings = '{0, 32, 63, 1, 33, 0, 0};
        settings[5] = $urandom_range(2, 31);
        settings[6] = $urandom_range(0, 63);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axis extremes, including the wrap of -0x8000 and -0
        send_report(make_report(ID_MOTION, 1'b0, 16'hFFFF, 16'h0000, 16'h8000, 0, 0, 0));
        send_report(make_report(ID_MOTION, 1'b1, 16'h7FFF, 16'h8000, 16'h0001,
                                16'h0000, 16'hFFFF, 16'h0000));
        send_report(make_report(ID_ROTATE, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 0, 0));
        // bitwise scan limited to the reset width of 16
        send_report(make_report(ID_BITS, 1'b0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        send_report(make_report(ID_BITS, 1'b0, 16'h0000, 16'h0000, 0, 0, 0, 0));
        send_report(make_report(ID_BITS, 1'b0, 16'h8001, 16'h0001, 0, 0, 0, 0));
        // dual-function: all 32 bits, the most events one report can give
        send_report(make_report(ID_DUAL, 1'b0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        send_report(make_report(ID_DUAL, 1'b1, 16'hAAAA, 16'h5555, 0, 0, 0, 0));
        send_report(make_report(ID_DUAL, 1'b0, 16'h0000, 16'h0000, 0, 0, 0, 0));
        // key codes: cutoff at 32, duplicate new codes, zero slots, releases
        send_report(make_report(ID_KEYS, 1'b0, 16'd32, 16'd33, 16'hFFFF, 16'd33, 16'd0,
                                16'd1));
        send_report(make_report(ID_KEYS, 1'b0, 16'd33, 16'd0, 16'd0, 16'd0, 16'd0, 16'd40));
        send_report(make_report(ID_KEYS, 1'b0, 0, 0, 0, 0, 0, 0));
        // held key: zero start, repeat press, swap, release, extreme code
        send_report(make_report(ID_HELD, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        send_report(make_report(ID_HELD, 1'b0, 16'h0041, 0, 0, 0, 0, 0));
        send_report(make_report(ID_HELD, 1'b0, 16'h0041, 0, 0, 0, 0, 0));
        send_report(make_report(ID_HELD, 1'b0, 16'h0042, 0, 0, 0, 0, 0));
        send_report(make_report(ID_HELD, 1'b0, 16'h0000, 0, 0, 0, 0, 0));
        send_report(make_report(ID_HELD, 1'b0, 16'hFFFF, 0, 0, 0, 0, 0));
        // unknown ids give nothing and leave state alone
        send_report(make_report(8'h00, 1'b1, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        send_report(make_report(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        send_report(make_report(8'h04, 1'b1, 16'h1234, 16'h5678, 0, 0, 0, 0));

        foreach (settings[p]) begin
            wait_drained();
            write_bits_in_use(CFG_W'(settings[p]));
            repeat (PHASE_ITEMS) send_report(random_report());
        end
        wait_drained();

        if (sb.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Event sink with random back-pressure.
    initial begin
        int   gap;
        res_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got.kind    = event_kind_t'(event_kind);
            got.x       = axis_x;
            got.y       = axis_y;
            got.z       = axis_z;
            got.button  = button;
            got.pressed = pressed;
            got.last    = last;
            sb.check_event(got);
        end
    end

    // Watchdog: count cycles without any transfer on any channel.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/shad_pkg.sv
hw/rtl/shad_fifo.sv
hw/rtl/shad_front.sv
hw/rtl/shad_back.sv
hw/rtl/six_axis_hid_report_decoder.sv
verif/tb_six_axis_hid_report_decoder.sv
